// ----- rtl/core/rrl_pkg.sv -----
// Shared types, constants and constant tables of the ripple rainbow frame generator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rrl_pkg;

   localparam int GRID_W     = 5;
   localparam int GRID_H     = 5;
   localparam int ANGLE_BITS = 10;

   localparam int TICK_W     = 32;
   localparam int COORD_W    = 4;
   localparam int COLOR_W    = 8;
   localparam int INTERVAL_W = 10;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [COORD_W-1:0] COL_LAST = COORD_W'(GRID_W - 1);
   localparam logic [COORD_W-1:0] ROW_LAST = COORD_W'(GRID_H - 1);

   // Time phase is bits [26-ANGLE_BITS +: ANGLE_BITS] of tick * 53403.
   localparam int              TIME_MUL_W = 16;
   localparam logic [15:0]     TIME_MUL   = 16'd53403;
   localparam int              TPH_LSB    = 26 - ANGLE_BITS;
   // tick / 10 is (tick * RECIP10) >> 35 for every 32-bit tick.
   localparam logic [31:0]     RECIP10    = 32'hCCCC_CCCD;
   localparam int              QUOT_W     = 29;

   localparam logic [7:0]      HUE_SPAN   = 8'd43;
   localparam logic [7:0]      COLOR_MAX  = 8'd255;

   localparam int SINE_DEPTH = 1 << (ANGLE_BITS - 2);
   localparam int SINE_IDX_W = ANGLE_BITS - 2;
   localparam int DANG_DEPTH = 1 << (2 * COORD_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_INTERVAL,
      CSR_SATURATION,
      CSR_CENTER_COL,
      CSR_CENTER_ROW
   } csr_index_type;

   typedef enum logic [2:0] {
      HUE_RED_YELLOW,
      HUE_YELLOW_GREEN,
      HUE_GREEN_CYAN,
      HUE_CYAN_BLUE,
      HUE_BLUE_MAGENTA,
      HUE_MAGENTA_RED
   } hue_region_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] frame_interval;
      logic [COLOR_W-1:0]    saturation;
      logic [COORD_W-1:0]    center_col;
      logic [COORD_W-1:0]    center_row;
   } csr_type;

   // Per-frame values the back end needs to render one frame; the grid centre comes from the CSRs.
   typedef struct packed {
      logic [ANGLE_BITS-1:0] tphase;
      hue_region_type        region;
      logic [COLOR_W-1:0]    kp;
      logic [COLOR_W-1:0]    kq;
      logic [COLOR_W-1:0]    kt;
      logic                  sat_zero;
   } job_type;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               last;
   } pixel_type;

   typedef logic [COLOR_W-1:0]    sine_lut_type [SINE_DEPTH];
   typedef logic [ANGLE_BITS-1:0] dang_lut_type [DANG_DEPTH];

   // Brightness of a quarter-wave phase q, using a truncated Q30 Taylor series.
   function automatic logic [COLOR_W-1:0] sine_level(input logic [63:0] q);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t3;
      logic [63:0] t5;
      logic [63:0] t7;
      logic [63:0] t9;
      logic [63:0] s;
      logic [63:0] v;
      x  = (q * 64'd1686629713) >> (ANGLE_BITS - 2);
      x2 = (x * x) >> 30;
      t3 = ((x * x2) >> 30) / 64'd6;
      t5 = ((t3 * x2) >> 30) / 64'd20;
      t7 = ((t5 * x2) >> 30) / 64'd42;
      t9 = ((t7 * x2) >> 30) / 64'd72;
      s  = x - t3 + t5 - t7 + t9;
      v  = (s * 64'd255) >> 30;
      return (v > 64'd255) ? COLOR_MAX : v[COLOR_W-1:0];
   endfunction

   // Entry i holds the level of quarter-wave phase i + 1.
   function automatic sine_lut_type build_sine_lut();
      sine_lut_type lut;
      for (int i = 0; i < SINE_DEPTH; i++) begin
         lut[i] = sine_level(64'(i + 1));
      end
      return lut;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitv;
      rem  = n;
      root = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Distance angle indexed by {|dy|, |dx|}.
   function automatic dang_lut_type build_dang_lut();
      dang_lut_type lut;
      logic [63:0]  d2;
      logic [63:0]  root;
      logic [63:0]  ang;
      for (int dy = 0; dy < (1 << COORD_W); dy++) begin
         for (int dx = 0; dx < (1 << COORD_W); dx++) begin
            d2   = 64'(dx * dx + dy * dy);
            root = isqrt64(d2 << 32);
            ang  = (root * 64'd683565276) >> (48 - ANGLE_BITS);
            lut[dy * (1 << COORD_W) + dx] = ang[ANGLE_BITS-1:0];
         end
      end
      return lut;
   endfunction

   localparam sine_lut_type SINE_LUT = build_sine_lut();
   localparam dang_lut_type DANG_LUT = build_dang_lut();

endpackage

// ----- rtl/core/rrl_front.sv -----
// Front end: takes ticks, decides whether a frame is due and prepares the frame job.
// Depends on rrl_pkg; feeds rrl_queue.
`timescale 1ns / 1ps

module rrl_front import rrl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [TICK_W-1:0] in_tick,
   input  csr_type           csr,
   output logic              push,
   output job_type           push_job,
   input  logic              full
);

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_MUL,
      FR_FOLD,
      FR_HUE,
      FR_REGION,
      FR_SCALE,
      FR_PUSH
   } front_state_type;

   front_state_type       state_ff;
   logic [TICK_W-1:0]     last_tick_ff;
   logic [TICK_W-1:0]     tick_ff;
   logic [QUOT_W-1:0]     quot_ff;
   logic [9:0]            sum_ff;
   logic [COLOR_W-1:0]    hue_ff;
   logic [COLOR_W-1:0]    rem_ff;
   job_type               job_ff;

   logic                  due;
   logic [TICK_W-1:0]     elapsed;
   logic [26+TIME_MUL_W-1:0] tprod;
   logic [63:0]           qprod;
   logic [ANGLE_BITS-1:0] tphase_in;
   logic [QUOT_W-1:0]     quot_in;
   logic [9:0]            sum_in;
   logic [8:0]            fold;
   logic [COLOR_W-1:0]    hue_in;
   hue_region_type        region_in;
   logic [COLOR_W-1:0]    base;
   logic [COLOR_W-1:0]    diff;
   logic [COLOR_W-1:0]    rem_in;
   logic [15:0]           sq_prod;
   logic [15:0]           st_prod;

   always_comb begin
      elapsed = in_tick - last_tick_ff;
      due     = elapsed >= TICK_W'(csr.frame_interval);

      tprod     = tick_ff[25:0] * TIME_MUL;
      tphase_in = tprod[TPH_LSB +: ANGLE_BITS];
      qprod     = 64'(tick_ff) * 64'(RECIP10);
      quot_in   = qprod[63:35];

      // The quotient modulo 255 is its byte sum modulo 255.
      sum_in = 10'(quot_ff[7:0]) + 10'(quot_ff[15:8]) + 10'(quot_ff[23:16])
             + 10'(quot_ff[28:24]);
      fold   = 9'(sum_ff[7:0]) + 9'(sum_ff[9:8]);
      hue_in = (fold >= 9'(COLOR_MAX)) ? 8'(fold - 9'(COLOR_MAX)) : fold[7:0];

      if (hue_ff < HUE_SPAN) begin
         region_in = HUE_RED_YELLOW;
         base      = 8'd0;
      end else if (hue_ff < 8'(2 * HUE_SPAN)) begin
         region_in = HUE_YELLOW_GREEN;
         base      = HUE_SPAN;
      end else if (hue_ff < 8'(3 * HUE_SPAN)) begin
         region_in = HUE_GREEN_CYAN;
         base      = 8'(2 * HUE_SPAN);
      end else if (hue_ff < 8'(4 * HUE_SPAN)) begin
         region_in = HUE_CYAN_BLUE;
         base      = 8'(3 * HUE_SPAN);
      end else if (hue_ff < 8'(5 * HUE_SPAN)) begin
         region_in = HUE_BLUE_MAGENTA;
         base      = 8'(4 * HUE_SPAN);
      end else begin
         region_in = HUE_MAGENTA_RED;
         base      = 8'(5 * HUE_SPAN);
      end
      diff   = hue_ff - base;
      rem_in = 8'(diff * 8'd6);

      sq_prod = csr.saturation * rem_ff;
      st_prod = csr.saturation * (COLOR_MAX - rem_ff);
   end

   assign in_ready = (state_ff == FR_IDLE);
   assign push     = (state_ff == FR_PUSH) && !full;
   assign push_job = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FR_IDLE;
         last_tick_ff <= '0;
      end else begin
         case (state_ff)
            FR_IDLE: begin
               if (in_valid && due) begin
                  last_tick_ff <= in_tick;
                  tick_ff      <= in_tick;
                  state_ff     <= FR_MUL;
               end
            end
            FR_MUL: begin
               job_ff.tphase <= tphase_in;
               quot_ff       <= quot_in;
               state_ff      <= FR_FOLD;
            end
            FR_FOLD: begin
               sum_ff   <= sum_in;
               state_ff <= FR_HUE;
            end
            FR_HUE: begin
               hue_ff   <= hue_in;
               state_ff <= FR_REGION;
            end
            FR_REGION: begin
               job_ff.region <= region_in;
               rem_ff        <= rem_in;
               state_ff      <= FR_SCALE;
            end
            FR_SCALE: begin
               job_ff.kp       <= COLOR_MAX - csr.saturation;
               job_ff.kq       <= COLOR_MAX - sq_prod[15:8];
               job_ff.kt       <= COLOR_MAX - st_prod[15:8];
               job_ff.sat_zero <= (csr.saturation == '0);
               state_ff        <= FR_PUSH;
            end
            FR_PUSH: begin
               if (!full) begin
                  state_ff <= FR_IDLE;
               end
            end
            default: begin
               state_ff <= FR_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/core/rrl_queue.sv -----
// Short job queue between the front end and the pixel back end.
// Depends on rrl_pkg for the job type and depth.
`timescale 1ns / 1ps

module rrl_queue import rrl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    out_valid,
   output job_type out_job,
   input  logic    pop
);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/core/rrl_back.sv -----
// Back end: walks the grid for one frame job and renders each pixel in a short pipeline.
// Depends on rrl_pkg for the distance and sine tables and the shared types.
`timescale 1ns / 1ps

module rrl_back import rrl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      job_valid,
   input  job_type   job,
   output logic      job_pop,
   input  csr_type   csr,
   output logic      out_valid,
   input  logic      out_ready,
   output pixel_type out_pix
);

   logic                  busy_ff;
   logic [COORD_W-1:0]    col_ff;
   logic [COORD_W-1:0]    row_ff;
   job_type               job_ff;

   logic                  s1_valid_ff;
   logic [COORD_W-1:0]    s1_col_ff;
   logic [COORD_W-1:0]    s1_row_ff;
   logic                  s1_last_ff;
   logic [ANGLE_BITS-1:0] s1_phase_ff;

   logic                  s2_valid_ff;
   logic [COORD_W-1:0]    s2_col_ff;
   logic [COORD_W-1:0]    s2_row_ff;
   logic                  s2_last_ff;
   logic [COLOR_W-1:0]    s2_level_ff;

   logic                  out_valid_ff;
   pixel_type             out_pix_ff;

   logic                  advance;
   logic                  at_last;
   logic [COORD_W-1:0]    adx;
   logic [COORD_W-1:0]    ady;
   logic [ANGLE_BITS-1:0] phase_in;
   logic                  lit;
   logic [ANGLE_BITS-2:0] ph_low;
   logic [ANGLE_BITS-2:0] qphase;
   logic [SINE_IDX_W-1:0] sine_idx;
   logic [COLOR_W-1:0]    level_in;
   logic [15:0]           p_prod;
   logic [15:0]           q_prod;
   logic [15:0]           t_prod;
   logic [COLOR_W-1:0]    pv;
   logic [COLOR_W-1:0]    qv;
   logic [COLOR_W-1:0]    tv;
   pixel_type             pix_in;

   // The whole pipeline holds while the output register is full and not taken.
   assign advance = !out_valid_ff || out_ready;
   // A new frame starts only after the previous one has left the inner stages.
   assign job_pop = job_valid && !busy_ff && !s1_valid_ff && !s2_valid_ff;
   assign at_last = (col_ff == COL_LAST) && (row_ff == ROW_LAST);

   always_comb begin
      adx      = (col_ff >= csr.center_col) ? col_ff - csr.center_col
                                            : csr.center_col - col_ff;
      ady      = (row_ff >= csr.center_row) ? row_ff - csr.center_row
                                            : csr.center_row - row_ff;
      phase_in = DANG_LUT[{ady, adx}] - job_ff.tphase;

      // Only the open lower half-turn lights; fold it onto the quarter wave.
      lit    = (s1_phase_ff != '0) && !s1_phase_ff[ANGLE_BITS-1];
      ph_low = s1_phase_ff[ANGLE_BITS-2:0];
      if (ph_low <= (ANGLE_BITS-1)'(SINE_DEPTH)) begin
         qphase = ph_low;
      end else begin
         qphase = (ANGLE_BITS-1)'(2 * SINE_DEPTH) - ph_low;
      end
      sine_idx = SINE_IDX_W'(qphase - 1'b1);
      level_in = lit ? SINE_LUT[sine_idx] : '0;

      p_prod = s2_level_ff * job_ff.kp;
      q_prod = s2_level_ff * job_ff.kq;
      t_prod = s2_level_ff * job_ff.kt;
      pv     = p_prod[15:8];
      qv     = q_prod[15:8];
      tv     = t_prod[15:8];

      pix_in.col  = s2_col_ff;
      pix_in.row  = s2_row_ff;
      pix_in.last = s2_last_ff;
      if (job_ff.sat_zero) begin
         pix_in.red   = s2_level_ff;
         pix_in.green = s2_level_ff;
         pix_in.blue  = s2_level_ff;
      end else begin
         case (job_ff.region)
            HUE_RED_YELLOW: begin
               pix_in.red = s2_level_ff; pix_in.green = tv; pix_in.blue = pv;
            end
            HUE_YELLOW_GREEN: begin
               pix_in.red = qv; pix_in.green = s2_level_ff; pix_in.blue = pv;
            end
            HUE_GREEN_CYAN: begin
               pix_in.red = pv; pix_in.green = s2_level_ff; pix_in.blue = tv;
            end
            HUE_CYAN_BLUE: begin
               pix_in.red = pv; pix_in.green = qv; pix_in.blue = s2_level_ff;
            end
            HUE_BLUE_MAGENTA: begin
               pix_in.red = tv; pix_in.green = pv; pix_in.blue = s2_level_ff;
            end
            default: begin
               pix_in.red = s2_level_ff; pix_in.green = pv; pix_in.blue = qv;
            end
         endcase
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pix   = out_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (job_pop) begin
            job_ff  <= job;
            busy_ff <= 1'b1;
            col_ff  <= '0;
            row_ff  <= '0;
         end
         if (advance) begin
            s1_valid_ff <= busy_ff;
            if (busy_ff) begin
               s1_col_ff   <= col_ff;
               s1_row_ff   <= row_ff;
               s1_last_ff  <= at_last;
               s1_phase_ff <= phase_in;
               if (col_ff == COL_LAST) begin
                  col_ff <= '0;
                  if (row_ff == ROW_LAST) begin
                     busy_ff <= 1'b0;
                  end else begin
                     row_ff <= row_ff + 1'b1;
                  end
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            s2_valid_ff <= s1_valid_ff;
            s2_col_ff   <= s1_col_ff;
            s2_row_ff   <= s1_row_ff;
            s2_last_ff  <= s1_last_ff;
            s2_level_ff <= level_in;
            out_valid_ff <= s2_valid_ff;
            if (s2_valid_ff) begin
               out_pix_ff <= pix_in;
            end
         end
      end
   end

endmodule

// ----- rtl/core/ripple_rainbow_led_frame_generator_core.sv -----
// Top level of the ripple rainbow frame generator: configuration registers and wiring.
// Depends on rrl_pkg, rrl_front, rrl_queue and rrl_back.
`timescale 1ns / 1ps

// Each request carries a millisecond tick. A tick that comes less than frame_interval
// after the last frame tick is consumed and produces nothing. A due tick occupies the
// front end (time-phase and divide-by-ten multipliers, modulo-255 byte fold, hue
// region, saturation scaling) until it becomes a frame job in a two-entry queue. The
// back end renders a job as 25 pixel responses, one per cycle while rsp_tready allows,
// row by row, through a three-stage pipeline (distance table, sine table, HSV
// multipliers); tlast marks the last pixel. Configuration writes are taken at any cycle
// but should only occur while no frame is in flight.
module ripple_rainbow_led_frame_generator_core import rrl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] tick_time
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [3:0] pix_col, [7:4] pix_row, [15:8] red,
                                              // [23:16] green, [31:24] blue
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csr_type   csr_ff;
   logic      job_push;
   job_type   push_job;
   logic      queue_full;
   logic      job_valid;
   job_type   queue_job;
   logic      job_pop;
   pixel_type pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.frame_interval <= INTERVAL_W'(50);
         csr_ff.saturation     <= COLOR_MAX;
         csr_ff.center_col     <= COORD_W'(2);
         csr_ff.center_row     <= COORD_W'(2);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_INTERVAL: csr_ff.frame_interval <= csr_wdata[INTERVAL_W-1:0];
            CSR_SATURATION:     csr_ff.saturation     <= csr_wdata[COLOR_W-1:0];
            CSR_CENTER_COL:     csr_ff.center_col     <= csr_wdata[COORD_W-1:0];
            CSR_CENTER_ROW:     csr_ff.center_row     <= csr_wdata[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rrl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_tick  (req_tdata),
      .csr      (csr_ff),
      .push     (job_push),
      .push_job (push_job),
      .full     (queue_full)
   );

   rrl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .full      (queue_full),
      .out_valid (job_valid),
      .out_job   (queue_job),
      .pop       (job_pop)
   );

   rrl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (queue_job),
      .job_pop   (job_pop),
      .csr       (csr_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pix   (pix)
   );

   assign rsp_tdata = {pix.blue, pix.green, pix.red, pix.row, pix.col};
   assign rsp_tlast = pix.last;

   a_last_at_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == ((rsp_tdata[3:0] == COL_LAST)
                                    && (rsp_tdata[7:4] == ROW_LAST))))
      else $error("tlast does not match the last grid pixel");

   a_pixel_on_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[3:0] <= COL_LAST) && (rsp_tdata[7:4] <= ROW_LAST)))
      else $error("pixel coordinate outside the grid");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !queue_full)
      else $error("frame job pushed into a full queue");

endmodule
